// ===== design/rau_pkg.sv =====
// shared types, constants and helper functions of the rational arithmetic unit
package rau_pkg;

    localparam int WIDTH = 16;
    localparam int MW    = WIDTH;
    localparam int PW    = 2 * WIDTH;
    localparam int DW    = 2 * WIDTH + 1;
    localparam int NUM_W = 34;
    localparam int DEN_W = 32;
    localparam int CW    = $clog2(DW + 1);
    localparam int KW    = $clog2(DW);
    localparam int XW    = 72;

    typedef enum logic [2:0] {
        MODE_ADD  = 3'd0,
        MODE_SUB  = 3'd1,
        MODE_MUL  = 3'd2,
        MODE_DIV  = 3'd3,
        MODE_SIGN = 3'd4,
        MODE_CMP  = 3'd5,
        MODE_LCD  = 3'd6,
        MODE_BAD  = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        REL_LESS    = 2'd0,
        REL_EQ      = 2'd1,
        REL_GREATER = 2'd2
    } t_rel;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_GCD_AB,
        CMD_DIV_FA,
        CMD_DIV_FB,
        CMD_MUL0,
        CMD_MUL1,
        CMD_MUL2,
        CMD_COMB,
        CMD_GCD_ND,
        CMD_DIV_N,
        CMD_DIV_D,
        CMD_OUT
    } t_cmd;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GCD1,
        ST_GCD1_WAIT,
        ST_DIVA,
        ST_DIVA_WAIT,
        ST_DIVB,
        ST_DIVB_WAIT,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_COMB,
        ST_GCD2,
        ST_GCD2_WAIT,
        ST_DIVN,
        ST_DIVN_WAIT,
        ST_DIVD,
        ST_DIVD_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic  bad;
        t_mode mode;
        logic  gcd_done;
        logic  div_done;
    } t_stat;

    // {neg, magnitude} of the low WIDTH bits read as two's complement
    function automatic logic [MW:0] take_signed(input logic [15:0] raw);
        logic [WIDTH-1:0] v;
        logic             neg;
        logic [MW-1:0]    mag;
        v   = WIDTH'(raw);
        neg = v[WIDTH-1];
        mag = neg ? MW'(~v + 1'b1) : MW'(v);
        return {neg, mag};
    endfunction

    // saturating two's complement encode of a sign-magnitude value
    function automatic logic [NUM_W-1:0] enc_num(input logic neg, input logic [DW-1:0] mag);
        logic [XW-1:0] m;
        logic [XW-1:0] lim;
        m   = XW'(mag);
        lim = XW'(1) << (NUM_W - 1);
        if (neg && (m != '0)) begin
            if (m > lim) m = lim;
            return NUM_W'(~m + XW'(1));
        end
        if (m > lim - XW'(1)) m = lim - XW'(1);
        return NUM_W'(m);
    endfunction

    function automatic logic [DEN_W-1:0] enc_den(input logic [DW-1:0] d);
        logic [XW-1:0] m;
        m = XW'(d);
        if (m > XW'({DEN_W{1'b1}})) return {DEN_W{1'b1}};
        return DEN_W'(m);
    endfunction

endpackage

// ===== design/rational_arithmetic_unit.sv =====
// errors and sign go from the check straight to the output; compare and common
// denominator take one gcd pass and two divisions; the others also take a second gcd
// pass and two more divisions
// throughput: one transaction at a time, set by the shared gcd engine and divider;
// a finished result waits in the output register while the next transaction is taken
// reset: synchronous active low, clears the sequencer state and the valid, busy and done flags only
// top level of the rational arithmetic unit
module rational_arithmetic_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [2:0]                i_mode,
    input  logic signed [15:0]        i_a_num,
    input  logic signed [15:0]        i_a_den,
    input  logic signed [15:0]        i_b_num,
    input  logic signed [15:0]        i_b_den,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [33:0]        o_res_num,
    output logic [31:0]               o_res_den,
    output logic signed [33:0]        o_second_num,
    output logic [1:0]                o_relation,
    output logic                      o_error
);
    rau_pkg::t_cmd  cmd;
    rau_pkg::t_stat stat;

    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rau_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_mode       (i_mode),
        .i_a_num      (i_a_num),
        .i_a_den      (i_a_den),
        .i_b_num      (i_b_num),
        .i_b_den      (i_b_den),
        .o_res_num    (o_res_num),
        .o_res_den    (o_res_den),
        .o_second_num (o_second_num),
        .o_relation   (o_relation),
        .o_error      (o_error)
    );
endmodule

// ===== design/rau_gcd.sv =====
// binary gcd engine, one subtract or shift step per cycle
module rau_gcd (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [rau_pkg::DW-1:0] i_x,
    input  logic [rau_pkg::DW-1:0] i_y,
    output logic                   o_done,
    output logic [rau_pkg::DW-1:0] o_g
);
    logic [rau_pkg::DW-1:0] r_x, n_x, r_y, n_y;
    logic [rau_pkg::KW-1:0] r_k, n_k;
    logic                   r_busy, n_busy, r_done, n_done;

    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_k    = r_k;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            // a zero operand makes the other one the result
            n_x    = (i_x == '0) ? i_y : i_x;
            n_y    = (i_y == '0) ? i_x : i_y;
            n_k    = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_x == r_y) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else if (!r_x[0] && !r_y[0]) begin
                n_x = r_x >> 1;
                n_y = r_y >> 1;
                n_k = r_k + 1'b1;
            end else if (!r_x[0]) begin
                n_x = r_x >> 1;
            end else if (!r_y[0]) begin
                n_y = r_y >> 1;
            end else if (r_x > r_y) begin
                n_x = r_x - r_y;
            end else begin
                n_y = r_y - r_x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_k <= n_k;
    end

    assign o_done = r_done;
    assign o_g    = r_x << r_k;
endmodule

// ===== design/rau_div.sv =====
// restoring divider, one quotient bit per cycle
module rau_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [rau_pkg::DW-1:0] i_dividend,
    input  logic [rau_pkg::DW-1:0] i_divisor,
    output logic                   o_done,
    output logic [rau_pkg::DW-1:0] o_quo
);
    logic [rau_pkg::DW-1:0] r_rem, n_rem, r_quo, n_quo, r_dvs, n_dvs;
    logic [rau_pkg::CW-1:0] r_cnt, n_cnt;
    logic                   r_busy, n_busy, r_done, n_done;
    logic [rau_pkg::DW:0]   trial;
    logic                   ge;

    always_comb begin
        trial  = {r_rem, r_quo[rau_pkg::DW-1]};
        ge     = trial >= {1'b0, r_dvs};
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = ge ? rau_pkg::DW'(trial - {1'b0, r_dvs}) : rau_pkg::DW'(trial);
            n_quo = {r_quo[rau_pkg::DW-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == rau_pkg::CW'(rau_pkg::DW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== design/rau_datapath.sv =====
// operand registers, shared multiplier, gcd and divider, result registers
module rau_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rau_pkg::t_cmd             i_cmd,
    output rau_pkg::t_stat            o_stat,
    input  logic [2:0]                i_mode,
    input  logic [15:0]               i_a_num,
    input  logic [15:0]               i_a_den,
    input  logic [15:0]               i_b_num,
    input  logic [15:0]               i_b_den,
    output logic [rau_pkg::NUM_W-1:0] o_res_num,
    output logic [rau_pkg::DEN_W-1:0] o_res_den,
    output logic [rau_pkg::NUM_W-1:0] o_second_num,
    output logic [1:0]                o_relation,
    output logic                      o_error
);
    localparam int MW = rau_pkg::MW;
    localparam int PW = rau_pkg::PW;
    localparam int DW = rau_pkg::DW;

    rau_pkg::t_mode r_mode;
    rau_pkg::t_rel  r_rel;
    rau_pkg::t_cmd  r_div_dst;
    logic           r_bad, r_an_neg, r_bn_neg, r_n_neg;
    logic [MW-1:0]  r_an, r_ad, r_bn, r_bd, r_fa, r_fb;
    logic [PW-1:0]  r_p0, r_p1, r_p2, r_den;
    logic [DW-1:0]  r_n, r_nq, r_dq;

    logic [rau_pkg::NUM_W-1:0] r_res_num, r_second_num;
    logic [rau_pkg::DEN_W-1:0] r_res_den;
    logic [1:0]                r_relation;
    logic                      r_error;

    logic [MW:0]   sa, sd, sb, sbd;
    logic          a_neg_eff, b_neg_eff, bad;
    logic [MW-1:0] mul_x, mul_y;
    logic [PW-1:0] prod;
    logic          gcd_start, gcd_done, div_start, div_done;
    logic [DW-1:0] gcd_x, gcd_y, g, div_a, div_b, quo;
    logic          sb_neg, sum_neg;
    logic [DW-1:0] sum_a, sum_b, sum_mag;

    // input decode: fold each denominator sign into its numerator and flag invalid operands
    always_comb begin
        sa  = rau_pkg::take_signed(i_a_num);
        sd  = rau_pkg::take_signed(i_a_den);
        sb  = rau_pkg::take_signed(i_b_num);
        sbd = rau_pkg::take_signed(i_b_den);
        a_neg_eff = (sa[MW-1:0] != '0) && (sa[MW] ^ sd[MW]);
        b_neg_eff = (sb[MW-1:0] != '0) && (sb[MW] ^ sbd[MW]);
        bad = (i_mode == rau_pkg::MODE_BAD) || (sd[MW-1:0] == '0) ||
              ((i_mode != rau_pkg::MODE_SIGN) && (sbd[MW-1:0] == '0)) ||
              ((i_mode == rau_pkg::MODE_DIV) && (sb[MW-1:0] == '0));
    end

    // shared multiplier operand select
    always_comb begin
        mul_x = r_an;
        mul_y = r_fa;
        case (i_cmd)
            rau_pkg::CMD_MUL0: begin
                mul_x = r_an;
                mul_y = (r_mode == rau_pkg::MODE_MUL) ? r_bn :
                        (r_mode == rau_pkg::MODE_DIV) ? r_bd : r_fa;
            end
            rau_pkg::CMD_MUL1: begin
                mul_x = r_bn;
                mul_y = r_fb;
            end
            rau_pkg::CMD_MUL2: begin
                mul_x = r_ad;
                mul_y = (r_mode == rau_pkg::MODE_MUL) ? r_bd :
                        (r_mode == rau_pkg::MODE_DIV) ? r_bn : r_fa;
            end
            default: begin
                mul_x = r_an;
                mul_y = r_fa;
            end
        endcase
        prod = mul_x * mul_y;
    end

    always_comb begin
        gcd_start = (i_cmd == rau_pkg::CMD_GCD_AB) || (i_cmd == rau_pkg::CMD_GCD_ND);
        gcd_x     = (i_cmd == rau_pkg::CMD_GCD_ND) ? r_n : DW'(r_ad);
        gcd_y     = (i_cmd == rau_pkg::CMD_GCD_ND) ? DW'(r_den) : DW'(r_bd);
        div_start = 1'b1;
        div_a     = DW'(r_bd);
        case (i_cmd)
            rau_pkg::CMD_DIV_FA: div_a = DW'(r_bd);
            rau_pkg::CMD_DIV_FB: div_a = DW'(r_ad);
            rau_pkg::CMD_DIV_N:  div_a = r_n;
            rau_pkg::CMD_DIV_D:  div_a = DW'(r_den);
            default:             div_start = 1'b0;
        endcase
        div_b = g;
    end

    // signed sum of the scaled numerators, b negated for subtract and compare
    always_comb begin
        sb_neg = r_bn_neg ^ ((r_mode == rau_pkg::MODE_SUB) || (r_mode == rau_pkg::MODE_CMP));
        sum_a  = DW'(r_p0);
        sum_b  = DW'(r_p1);
        if (r_an_neg == sb_neg) begin
            sum_mag = sum_a + sum_b;
            sum_neg = r_an_neg;
        end else if (sum_a >= sum_b) begin
            sum_mag = sum_a - sum_b;
            sum_neg = r_an_neg;
        end else begin
            sum_mag = sum_b - sum_a;
            sum_neg = sb_neg;
        end
    end

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (gcd_start),
        .i_x     (gcd_x),
        .i_y     (gcd_y),
        .o_done  (gcd_done),
        .o_g     (g)
    );

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quo      (quo)
    );

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            rau_pkg::CMD_LOAD: begin
                r_mode   <= rau_pkg::t_mode'(i_mode);
                r_bad    <= bad;
                r_an_neg <= a_neg_eff;
                r_bn_neg <= b_neg_eff;
                r_an     <= sa[MW-1:0];
                r_ad     <= sd[MW-1:0];
                r_bn     <= sb[MW-1:0];
                r_bd     <= sbd[MW-1:0];
            end
            rau_pkg::CMD_MUL0: r_p0 <= prod;
            rau_pkg::CMD_MUL1: r_p1 <= prod;
            rau_pkg::CMD_MUL2: r_p2 <= prod;
            rau_pkg::CMD_COMB: begin
                if ((r_mode == rau_pkg::MODE_MUL) || (r_mode == rau_pkg::MODE_DIV)) begin
                    r_n     <= DW'(r_p0);
                    r_n_neg <= r_an_neg ^ r_bn_neg;
                end else begin
                    r_n     <= sum_mag;
                    r_n_neg <= sum_neg;
                end
                r_den <= r_p2;
                r_rel <= (sum_mag == '0) ? rau_pkg::REL_EQ :
                         sum_neg ? rau_pkg::REL_LESS : rau_pkg::REL_GREATER;
            end
            rau_pkg::CMD_OUT: begin
                r_res_num    <= '0;
                r_res_den    <= '0;
                r_second_num <= '0;
                r_relation   <= '0;
                r_error      <= 1'b0;
                if (r_bad) begin
                    r_error <= 1'b1;
                end else if (r_mode == rau_pkg::MODE_SIGN) begin
                    r_relation <= (r_an == '0) ? rau_pkg::REL_EQ :
                                  r_an_neg ? rau_pkg::REL_LESS : rau_pkg::REL_GREATER;
                end else if (r_mode == rau_pkg::MODE_CMP) begin
                    r_relation <= r_rel;
                end else if (r_mode == rau_pkg::MODE_LCD) begin
                    r_res_num    <= rau_pkg::enc_num(r_an_neg, DW'(r_p0));
                    r_res_den    <= rau_pkg::enc_den(DW'(r_p2));
                    r_second_num <= rau_pkg::enc_num(r_bn_neg, DW'(r_p1));
                end else begin
                    r_res_num <= rau_pkg::enc_num(r_n_neg, r_nq);
                    r_res_den <= rau_pkg::enc_den(r_dq);
                end
            end
            default: begin
            end
        endcase
        if (div_start) r_div_dst <= i_cmd;
        if (div_done) begin
            case (r_div_dst)
                rau_pkg::CMD_DIV_FA: r_fa <= MW'(quo);
                rau_pkg::CMD_DIV_FB: r_fb <= MW'(quo);
                rau_pkg::CMD_DIV_N:  r_nq <= quo;
                rau_pkg::CMD_DIV_D:  r_dq <= quo;
                default: begin
                end
            endcase
        end
    end

    assign o_stat.bad      = r_bad;
    assign o_stat.mode     = r_mode;
    assign o_stat.gcd_done = gcd_done;
    assign o_stat.div_done = div_done;

    assign o_res_num    = r_res_num;
    assign o_res_den    = r_res_den;
    assign o_second_num = r_second_num;
    assign o_relation   = r_relation;
    assign o_error      = r_error;
endmodule

// ===== design/rau_ctrl.sv =====
// sequencing state machine and handshake control
module rau_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  rau_pkg::t_stat i_stat,
    output rau_pkg::t_cmd  o_cmd
);
    rau_pkg::t_state r_state, n_state;
    rau_pkg::t_cmd   cmd;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rau_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = rau_pkg::CMD_NONE;
        case (r_state)
            rau_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    cmd     = rau_pkg::CMD_LOAD;
                    n_state = rau_pkg::ST_CHECK;
                end
            end
            rau_pkg::ST_CHECK: begin
                if (i_stat.bad || (i_stat.mode == rau_pkg::MODE_SIGN)) begin
                    n_state = rau_pkg::ST_OUT;
                end else begin
                    n_state = rau_pkg::ST_GCD1;
                end
            end
            rau_pkg::ST_GCD1: begin
                cmd     = rau_pkg::CMD_GCD_AB;
                n_state = rau_pkg::ST_GCD1_WAIT;
            end
            rau_pkg::ST_GCD1_WAIT: if (i_stat.gcd_done) n_state = rau_pkg::ST_DIVA;
            rau_pkg::ST_DIVA: begin
                cmd     = rau_pkg::CMD_DIV_FA;
                n_state = rau_pkg::ST_DIVA_WAIT;
            end
            rau_pkg::ST_DIVA_WAIT: if (i_stat.div_done) n_state = rau_pkg::ST_DIVB;
            rau_pkg::ST_DIVB: begin
                cmd     = rau_pkg::CMD_DIV_FB;
                n_state = rau_pkg::ST_DIVB_WAIT;
            end
            rau_pkg::ST_DIVB_WAIT: if (i_stat.div_done) n_state = rau_pkg::ST_MUL0;
            rau_pkg::ST_MUL0: begin
                cmd     = rau_pkg::CMD_MUL0;
                n_state = rau_pkg::ST_MUL1;
            end
            rau_pkg::ST_MUL1: begin
                cmd     = rau_pkg::CMD_MUL1;
                n_state = rau_pkg::ST_MUL2;
            end
            rau_pkg::ST_MUL2: begin
                cmd     = rau_pkg::CMD_MUL2;
                n_state = rau_pkg::ST_COMB;
            end
            rau_pkg::ST_COMB: begin
                cmd = rau_pkg::CMD_COMB;
                if ((i_stat.mode == rau_pkg::MODE_CMP) || (i_stat.mode == rau_pkg::MODE_LCD)) begin
                    n_state = rau_pkg::ST_OUT;
                end else begin
                    n_state = rau_pkg::ST_GCD2;
                end
            end
            rau_pkg::ST_GCD2: begin
                cmd     = rau_pkg::CMD_GCD_ND;
                n_state = rau_pkg::ST_GCD2_WAIT;
            end
            rau_pkg::ST_GCD2_WAIT: if (i_stat.gcd_done) n_state = rau_pkg::ST_DIVN;
            rau_pkg::ST_DIVN: begin
                cmd     = rau_pkg::CMD_DIV_N;
                n_state = rau_pkg::ST_DIVN_WAIT;
            end
            rau_pkg::ST_DIVN_WAIT: if (i_stat.div_done) n_state = rau_pkg::ST_DIVD;
            rau_pkg::ST_DIVD: begin
                cmd     = rau_pkg::CMD_DIV_D;
                n_state = rau_pkg::ST_DIVD_WAIT;
            end
            rau_pkg::ST_DIVD_WAIT: if (i_stat.div_done) n_state = rau_pkg::ST_OUT;
            rau_pkg::ST_OUT: begin
                // result register must be free or emptying this cycle
                if (!r_out_valid || i_out_ready) begin
                    cmd     = rau_pkg::CMD_OUT;
                    n_state = rau_pkg::ST_IDLE;
                end
            end
            default: n_state = rau_pkg::ST_IDLE;
        endcase
        n_out_valid = (r_out_valid && !i_out_ready) || (cmd == rau_pkg::CMD_OUT);
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == rau_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd == rau_pkg::CMD_OUT) |-> (!r_out_valid || i_out_ready))
        else $error("result written over a pending transaction");

    a_gcd_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.gcd_done |-> (r_state == rau_pkg::ST_GCD1_WAIT ||
                             r_state == rau_pkg::ST_GCD2_WAIT))
        else $error("gcd finished outside a wait state");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == rau_pkg::ST_DIVA_WAIT ||
                             r_state == rau_pkg::ST_DIVB_WAIT ||
                             r_state == rau_pkg::ST_DIVN_WAIT ||
                             r_state == rau_pkg::ST_DIVD_WAIT))
        else $error("division finished outside a wait state");

    a_load_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == rau_pkg::ST_CHECK))
        else $error("accepted transaction not checked");
endmodule

// ===== tb/sv/tb_rational_arithmetic_unit.sv =====
// self-checking testbench for the rational arithmetic unit
module tb_rational_arithmetic_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]  mode;
        logic [15:0] an;
        logic [15:0] ad;
        logic [15:0] bn;
        logic [15:0] bd;
    } t_op;

    typedef struct {
        logic [33:0] num;
        logic [31:0] den;
        logic [33:0] snum;
        logic [1:0]  rel;
        logic        err;
    } t_res;

    typedef struct {
        t_op  op;
        bit   typed;
        t_res res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_mode;
    logic signed [15:0] i_a_num, i_a_den, i_b_num, i_b_den;
    logic        o_out_valid;
    logic        i_out_ready;
    logic signed [33:0] o_res_num, o_second_num;
    logic [31:0] o_res_den;
    logic [1:0]  o_relation;
    logic        o_error;

    t_res pending_q[$];
    int   mismatches = 0;
    int   cycles = 0;
    bit   quiet_in = 0, quiet_out = 0;
    bit   hold_go = 0;
    int   hold_out = 0;
    bit   stim_done = 0;
    t_row rows[$];

    localparam int LIMIT = 3000000;
    localparam int HOLD_CYCLES = 2000;

    rational_arithmetic_unit dut (.*);

    always begin
        i_clk = 1'b0; #4;
        i_clk = 1'b1; #4;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // sign-magnitude arithmetic on wide unsigned values
    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic logic [33:0] to_num(bit neg, longint unsigned m);
        longint unsigned lim;
        lim = 64'd1 << 33;
        if (neg && m != 0) begin
            if (m > lim) m = lim;
            return 34'(-m);
        end
        if (m > lim - 1) m = lim - 1;
        return 34'(m);
    endfunction

    function automatic logic [31:0] to_den(longint unsigned d);
        return (d > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(d);
    endfunction

    function automatic void signed_add(bit xn, longint unsigned xm, bit yn,
                                       longint unsigned ym, output bit rn,
                                       output longint unsigned rm);
        if (xn == yn) begin
            rn = xn; rm = xm + ym;
        end else if (xm >= ym) begin
            rn = xn; rm = xm - ym;
        end else begin
            rn = yn; rm = ym - xm;
        end
        if (rm == 0) rn = 0;
    endfunction

    function automatic void reduce(bit n, longint unsigned m, longint unsigned d,
                                   inout t_res r);
        longint unsigned g;
        g = gcd64(m, d);
        m = m / g;
        d = d / g;
        r.num = to_num(n && m != 0, m);
        r.den = to_den(d);
    endfunction

    function automatic t_res predict_fraction(t_op op);
        t_res r;
        bit an_n, ad_n, bn_n, bd_n, sn, tn, rn;
        longint unsigned an_m, ad_m, bn_m, bd_m, g, fa, fb, lcm, sm, tm, rm;
        r = '{default: '0};
        an_n = op.an[15]; an_m = an_n ? 16'(-op.an) : op.an;
        ad_n = op.ad[15]; ad_m = ad_n ? 16'(-op.ad) : op.ad;
        bn_n = op.bn[15]; bn_m = bn_n ? 16'(-op.bn) : op.bn;
        bd_n = op.bd[15]; bd_m = bd_n ? 16'(-op.bd) : op.bd;
        if (op.an == 16'h8000) an_m = 32768;
        if (op.ad == 16'h8000) ad_m = 32768;
        if (op.bn == 16'h8000) bn_m = 32768;
        if (op.bd == 16'h8000) bd_m = 32768;
        if (op.mode == rau_pkg::MODE_BAD || ad_m == 0 ||
            (op.mode != rau_pkg::MODE_SIGN && bd_m == 0) ||
            (op.mode == rau_pkg::MODE_DIV && bn_m == 0)) begin
            r.err = 1'b1;
            return r;
        end
        if (ad_n) an_n = (an_m != 0) ? !an_n : 0;
        if (bd_n) bn_n = (bn_m != 0) ? !bn_n : 0;
        if (an_m == 0) an_n = 0;
        if (bn_m == 0) bn_n = 0;
        if (op.mode == rau_pkg::MODE_SIGN) begin
            r.rel = (an_m == 0) ? rau_pkg::REL_EQ :
                    (an_n ? rau_pkg::REL_LESS : rau_pkg::REL_GREATER);
            return r;
        end
        g = gcd64(ad_m, bd_m);
        fa = bd_m / g;
        fb = ad_m / g;
        lcm = ad_m * fa;
        sn = an_n; sm = an_m * fa;
        tn = bn_n; tm = bn_m * fb;
        case (op.mode)
            rau_pkg::MODE_ADD: begin
                signed_add(sn, sm, tn, tm, rn, rm);
                reduce(rn, rm, lcm, r);
            end
            rau_pkg::MODE_SUB: begin
                signed_add(sn, sm, (tm != 0) ? !tn : 0, tm, rn, rm);
                reduce(rn, rm, lcm, r);
            end
            rau_pkg::MODE_MUL: reduce(an_n != bn_n, an_m * bn_m, ad_m * bd_m, r);
            rau_pkg::MODE_DIV: reduce(an_n != bn_n, an_m * bd_m, ad_m * bn_m, r);
            rau_pkg::MODE_CMP: begin
                signed_add(sn, sm, (tm != 0) ? !tn : 0, tm, rn, rm);
                r.rel = (rm == 0) ? rau_pkg::REL_EQ :
                        (rn ? rau_pkg::REL_LESS : rau_pkg::REL_GREATER);
            end
            default: begin
                r.num = to_num(sn, sm);
                r.den = to_den(lcm);
                r.snum = to_num(tn, tm);
            end
        endcase
        return r;
    endfunction

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 8)) - 16'd4;
            1: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 14'($urandom)};
            2: return 16'($urandom_range(0, 200)) - 16'd100;
            3: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_op rand_op();
        t_op op;
        op.mode = ($urandom_range(0, 49) == 0) ? rau_pkg::MODE_BAD : 3'($urandom_range(0, 6));
        op.an = rand_field();
        op.ad = rand_field();
        op.bn = rand_field();
        op.bd = rand_field();
        // mostly well-formed fractions so the arithmetic path is exercised
        if ($urandom_range(0, 9) != 0) begin
            if (op.ad == 0) op.ad = 16'd1;
            if (op.bd == 0) op.bd = 16'hFFFF;
            if (op.mode == rau_pkg::MODE_DIV && op.bn == 0 && $urandom_range(0, 1))
                op.bn = 16'd3;
        end
        return op;
    endfunction

    // valid stays high after a transaction unless the sender idles
    task automatic send_op(t_row row);
        while (!quiet_in && $urandom_range(0, 99) < 26) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= row.op.mode;
        i_a_num <= row.op.an;
        i_a_den <= row.op.ad;
        i_b_num <= row.op.bn;
        i_b_den <= row.op.bd;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_q.push_back(row.typed ? row.res : predict_fraction(row.op));
        @(negedge i_clk);
    endtask

    function automatic t_row row_of(logic [2:0] m, logic [15:0] an, logic [15:0] ad,
                                    logic [15:0] bn, logic [15:0] bd, bit typed,
                                    t_res res);
        t_row r;
        r.op = '{m, an, ad, bn, bd};
        r.typed = typed;
        r.res = res;
        return r;
    endfunction

    // long receiver hold-off, counted in cycles
    always @(negedge i_clk) begin
        if (hold_go && hold_out < HOLD_CYCLES) hold_out <= hold_out + 1;
    end

    // receiver: random stalls plus the long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else if (hold_go && hold_out < HOLD_CYCLES) i_out_ready <= 1'b0;
        else i_out_ready <= quiet_out || ($urandom_range(0, 99) >= 26);
    end

    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction at cycle %0d", cycles);
            end else begin
                exp_r = pending_q.pop_front();
                if (o_res_num !== exp_r.num || o_res_den !== exp_r.den ||
                    o_second_num !== exp_r.snum || o_relation !== exp_r.rel ||
                    o_error !== exp_r.err) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp %0d/%0d %0d rel %0d err %0d, ",
                                  "got %0d/%0d %0d rel %0d err %0d"},
                                 $signed(exp_r.num), exp_r.den, $signed(exp_r.snum),
                                 exp_r.rel, exp_r.err, o_res_num, o_res_den,
                                 o_second_num, o_relation, o_error);
                end
            end
        end
    end

    initial begin
        t_res er;
        t_row rr;
        er = '{default: '0};
        er.err = 1'b1;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = '0;
        i_a_num = '0; i_a_den = '0; i_b_num = '0; i_b_den = '0;
        // error rows are typed in, the rest go through the predictor
        rows.push_back(row_of(rau_pkg::MODE_ADD, 16'd1, 16'd0, 16'd1, 16'd1, 1, er));
        rows.push_back(row_of(rau_pkg::MODE_SUB, 16'd1, 16'd2, 16'd1, 16'd0, 1, er));
        rows.push_back(row_of(rau_pkg::MODE_DIV, 16'd1, 16'd2, 16'd0, 16'd5, 1, er));
        rows.push_back(row_of(rau_pkg::MODE_BAD, 16'd1, 16'd2, 16'd3, 16'd5, 1, er));
        rows.push_back(row_of(rau_pkg::MODE_SIGN, 16'd5, 16'd0, 16'd3, 16'd0, 1, er));
        rows.push_back(row_of(rau_pkg::MODE_SIGN, 16'd5, 16'hFFFD, 16'd3, 16'd0, 0, er));
        rows.push_back(row_of(rau_pkg::MODE_SIGN, 16'd0, 16'd7, 16'd3, 16'd0, 0, er));
        rows.push_back(row_of(rau_pkg::MODE_ADD, 16'd1, 16'd2, 16'd1, 16'd3, 0, er));
        rows.push_back(row_of(rau_pkg::MODE_ADD, 16'd1, 16'd2, 16'hFFFF, 16'd2, 0, er));
        rows.push_back(row_of(rau_pkg::MODE_SUB, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                              0, er));
        rows.push_back(row_of(rau_pkg::MODE_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1, 0, er));
        rows.push_back(row_of(rau_pkg::MODE_MUL, 16'd6, 16'hFFF8, 16'd4, 16'd9, 0, er));
        rows.push_back(row_of(rau_pkg::MODE_DIV, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000,
                              0, er));
        rows.push_back(row_of(rau_pkg::MODE_DIV, 16'd3, 16'd4, 16'hFFFD, 16'hFFFC, 0, er));
        rows.push_back(row_of(rau_pkg::MODE_CMP, 16'd1, 16'd2, 16'd2, 16'd4, 0, er));
        rows.push_back(row_of(rau_pkg::MODE_CMP, 16'd1, 16'd2, 16'd2, 16'd3, 0, er));
        rows.push_back(row_of(rau_pkg::MODE_CMP, 16'hFFFF, 16'd2, 16'd1, 16'hFFFE, 0, er));
        rows.push_back(row_of(rau_pkg::MODE_LCD, 16'd1, 16'd6, 16'd1, 16'd4, 0, er));
        rows.push_back(row_of(rau_pkg::MODE_LCD, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                              0, er));
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[k]) send_op(rows[k]);
        for (int k = 0; k < 830; k++) begin
            quiet_in = (k >= 200 && k < 300);
            quiet_out = quiet_in;
            if (k == 400) hold_go = 1;
            if (k == 600) begin
                // sender pauses until every expected result has come
                i_in_valid <= 1'b0;
                do @(negedge i_clk); while (pending_q.size() != 0);
            end
            rr.op = rand_op();
            rr.typed = 0;
            rr.res = er;
            send_op(rr);
        end
        i_in_valid <= 1'b0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (mismatches == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
